// ===== sv/pirr_pkg.sv =====
// Package for the rotated rectangle hit test pipeline.
// Holds parameter defaults, trig constants, the quadrant codes and the fixed-point helper.
// No dependencies.
package pirr_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int ANGLE_BITS_DEF  = 16;

	localparam int TRIG_FRAC = 20;
	localparam int TRIG_UW   = TRIG_FRAC + 1;
	localparam int TRIG_SW   = TRIG_FRAC + 2;

	localparam logic [TRIG_UW-1:0] TRIG_ONE = TRIG_UW'(1) << TRIG_FRAC;
	localparam logic [TRIG_UW-1:0] POLY_A   = TRIG_UW'(1645969);
	localparam logic [TRIG_UW-1:0] POLY_B   = TRIG_UW'(670498);
	localparam logic [TRIG_UW-1:0] POLY_C   = TRIG_UW'(73105);

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	// Unsigned Q.20 product, truncated back to Q.20.
	function automatic logic [TRIG_UW-1:0] trig_mul(logic [TRIG_UW-1:0] a,
			logic [TRIG_UW-1:0] b);
		logic [2*TRIG_UW-1:0] p;
		p = (2*TRIG_UW)'(a) * (2*TRIG_UW)'(b);
		return p[TRIG_FRAC +: TRIG_UW];
	endfunction

endpackage

// ===== sv/pirr_cell.sv =====
// One cell of the pipeline chain: a valid bit and a payload word.
// The whole chain advances together on en. No package dependencies.
module pirr_cell #(
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vi,
	input  logic [W-1:0] d,
	output logic         vo,
	output logic [W-1:0] q
);

	logic         valid_q;
	logic [W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vi;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= d;
		end
	end

	assign vo = valid_q;
	assign q  = data_q;

endmodule

// ===== sv/pirr_skid.sv =====
// Input skid stage: holds one word taken while the chain is stalled.
// Its stall output is a register. No package dependencies.
module pirr_skid #(
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         stall,
	input  logic         en,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	logic         skid_v_q;
	logic [W-1:0] skid_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (en) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_valid && !en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_d_q <= in_data;
		end
	end

	assign stall     = skid_v_q;
	assign out_valid = skid_v_q | in_valid;
	assign out_data  = skid_v_q ? skid_d_q : in_data;

endmodule

// ===== sv/point_in_rotated_rect_test_core.sv =====
// Top level of the rotated rectangle hit test: skid stage plus a chain of ten cells.
// Depends on pirr_pkg, pirr_skid and pirr_cell.
//
// A test word on the input channel carries a rectangle center, its full sizes
// along its local x and z axes, a rotation about y and a query point. For each
// accepted word the block returns one word with hit, which is set when the
// point lies strictly inside the rotated rectangle and both heights round to
// the same integer, halfway values rounding away from zero.
// A word moves on a channel at a rising edge where valid is high and stall is low.
// The chain accepts one test word per cycle and returns one result word per
// cycle while result_stall does not hold it; an accepted word enters the first
// of the ten cells directly or from the skid stage, and result_valid rises
// when it reaches the tenth. The cells are angle split, three polynomial
// steps, scaling, quadrant select, products, truncation, sums and compare.
// When result_stall is high while a result waits, the chain holds; the skid
// stage still takes one more test word and then raises test_stall, which is
// a register. Reset clears every valid bit; no result is shown after reset
// until a test word arrives.
module point_in_rotated_rect_test_core #(
	parameter int COORD_WIDTH = pirr_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = pirr_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS  = pirr_pkg::ANGLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          test_valid,
	output logic                          test_stall,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic        [COORD_WIDTH-2:0] size_x,
	input  logic        [COORD_WIDTH-2:0] size_z,
	input  logic        [ANGLE_BITS-1:0]  turn_angle,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          hit
);

	import pirr_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int SXW = CW - 1;
	localparam int DW  = CW + 1;
	localparam int PW  = DW + TRIG_SW;
	localparam int QW  = CW + 2;
	localparam int LW  = CW + 3;
	localparam int RW  = CW + 1 - FRAC_BITS;
	localparam int ZPAD = TRIG_FRAC - (ANGLE_BITS - 2);
	localparam logic [CW:0] HALF = (CW+1)'((2 ** FRAC_BITS) >> 1);

	typedef struct packed {
		logic signed [CW-1:0]  cx;
		logic signed [CW-1:0]  cy;
		logic signed [CW-1:0]  cz;
		logic [SXW-1:0]        sx;
		logic [SXW-1:0]        sz;
		logic [ANGLE_BITS-1:0] ang;
		logic signed [CW-1:0]  px;
		logic signed [CW-1:0]  py;
		logic signed [CW-1:0]  pz;
	} word_t;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dz;
		logic [SXW-1:0]       sx;
		logic [SXW-1:0]       sz;
		quad_t                quad;
		logic [TRIG_UW-1:0]   zs;
		logic [TRIG_UW-1:0]   zc;
		logic [RW-1:0]        rc;
		logic [RW-1:0]        rp;
		logic                 nc;
		logic                 np;
	} s1_t;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dz;
		logic [SXW-1:0]       sx;
		logic [SXW-1:0]       sz;
		quad_t                quad;
		logic [TRIG_UW-1:0]   us;
		logic [TRIG_UW-1:0]   uc;
		logic [TRIG_UW-1:0]   u2s;
		logic [TRIG_UW-1:0]   u2c;
		logic                 level;
	} s2_t;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dz;
		logic [SXW-1:0]       sx;
		logic [SXW-1:0]       sz;
		quad_t                quad;
		logic [TRIG_UW-1:0]   us;
		logic [TRIG_UW-1:0]   uc;
		logic [TRIG_UW-1:0]   u2s;
		logic [TRIG_UW-1:0]   u2c;
		logic [TRIG_UW-1:0]   tbs;
		logic [TRIG_UW-1:0]   tbc;
		logic                 level;
	} s3_t;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dz;
		logic [SXW-1:0]       sx;
		logic [SXW-1:0]       sz;
		quad_t                quad;
		logic [TRIG_UW-1:0]   us;
		logic [TRIG_UW-1:0]   uc;
		logic [TRIG_UW-1:0]   tas;
		logic [TRIG_UW-1:0]   tac;
		logic                 level;
	} s4_t;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dz;
		logic [SXW-1:0]       sx;
		logic [SXW-1:0]       sz;
		quad_t                quad;
		logic [TRIG_UW-1:0]   ss;
		logic [TRIG_UW-1:0]   sc;
		logic                 level;
	} s5_t;

	typedef struct packed {
		logic signed [DW-1:0]      dx;
		logic signed [DW-1:0]      dz;
		logic [SXW-1:0]            sx;
		logic [SXW-1:0]            sz;
		logic signed [TRIG_SW-1:0] cs;
		logic signed [TRIG_SW-1:0] sn;
		logic                      level;
	} s6_t;

	typedef struct packed {
		logic signed [PW-1:0] pa;
		logic signed [PW-1:0] pb;
		logic signed [PW-1:0] pc;
		logic signed [PW-1:0] pd;
		logic [SXW-1:0]       sx;
		logic [SXW-1:0]       sz;
		logic                 level;
	} s7_t;

	typedef struct packed {
		logic signed [QW-1:0] qa;
		logic signed [QW-1:0] qb;
		logic signed [QW-1:0] qc;
		logic signed [QW-1:0] qd;
		logic [SXW-1:0]       sx;
		logic [SXW-1:0]       sz;
		logic                 level;
	} s8_t;

	typedef struct packed {
		logic signed [LW-1:0] lx;
		logic signed [LW-1:0] lz;
		logic [SXW-1:0]       sx;
		logic [SXW-1:0]       sz;
		logic                 level;
	} s9_t;

	typedef struct packed {
		logic hit;
	} s10_t;

	// Magnitude plus half an integer step, in one add.
	function automatic logic [CW:0] round_sum(logic signed [CW-1:0] v);
		logic [CW:0] a;
		a = v[CW-1] ? ~{v[CW-1], v} : {v[CW-1], v};
		return a + HALF + (CW+1)'(v[CW-1]);
	endfunction

	// Product scaled down by the trig fraction, truncated toward zero.
	function automatic logic signed [QW-1:0] trunc_q(logic signed [PW-1:0] p);
		logic signed [PW-1:0] sh;
		sh = p >>> TRIG_FRAC;
		return sh[QW-1:0] + QW'(p[PW-1] && (p[TRIG_FRAC-1:0] != '0));
	endfunction

	logic  en;
	logic  iw_v;
	word_t in_word;
	word_t iw;
	logic [CW:0] rsum_c;
	logic [CW:0] rsum_p;
	logic [TRIG_UW-1:0] z;
	logic signed [TRIG_SW-1:0] pos_s;
	logic signed [TRIG_SW-1:0] pos_c;
	logic signed [LW:0] lx2;
	logic signed [LW:0] lz2;
	logic signed [LW:0] sxe;
	logic signed [LW:0] sze;

	s1_t  s1_d, s1_q;
	s2_t  s2_d, s2_q;
	s3_t  s3_d, s3_q;
	s4_t  s4_d, s4_q;
	s5_t  s5_d, s5_q;
	s6_t  s6_d, s6_q;
	s7_t  s7_d, s7_q;
	s8_t  s8_d, s8_q;
	s9_t  s9_d, s9_q;
	s10_t s10_d, s10_q;
	logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v, s8_v, s9_v, s10_v;

	assign en = !s10_v || !result_stall;

	always_comb begin
		in_word.cx  = center_x;
		in_word.cy  = center_y;
		in_word.cz  = center_z;
		in_word.sx  = size_x;
		in_word.sz  = size_z;
		in_word.ang = turn_angle;
		in_word.px  = point_x;
		in_word.py  = point_y;
		in_word.pz  = point_z;
	end

	pirr_skid #(.W($bits(word_t))) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (test_valid),
		.in_data   (in_word),
		.stall     (test_stall),
		.en        (en),
		.out_valid (iw_v),
		.out_data  (iw)
	);

	// The angle splits into a quadrant and a position in it, scaled to Q.20.
	always_comb begin
		rsum_c     = round_sum(iw.cy);
		rsum_p     = round_sum(iw.py);
		z          = TRIG_UW'({iw.ang[ANGLE_BITS-3:0], ZPAD'(0)});
		s1_d.dx    = DW'(iw.px) - DW'(iw.cx);
		s1_d.dz    = DW'(iw.pz) - DW'(iw.cz);
		s1_d.sx    = iw.sx;
		s1_d.sz    = iw.sz;
		s1_d.quad  = quad_t'(iw.ang[ANGLE_BITS-1 -: 2]);
		s1_d.zs    = z;
		s1_d.zc    = TRIG_ONE - z;
		s1_d.rc    = rsum_c[CW:FRAC_BITS];
		s1_d.rp    = rsum_p[CW:FRAC_BITS];
		s1_d.nc    = iw.cy[CW-1];
		s1_d.np    = iw.py[CW-1];
	end

	pirr_cell #(.W($bits(s1_t))) u_s1 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (iw_v), .d (s1_d), .vo (s1_v), .q (s1_q)
	);

	always_comb begin
		s2_d.dx    = s1_q.dx;
		s2_d.dz    = s1_q.dz;
		s2_d.sx    = s1_q.sx;
		s2_d.sz    = s1_q.sz;
		s2_d.quad  = s1_q.quad;
		s2_d.us    = s1_q.zs;
		s2_d.uc    = s1_q.zc;
		s2_d.u2s   = trig_mul(s1_q.zs, s1_q.zs);
		s2_d.u2c   = trig_mul(s1_q.zc, s1_q.zc);
		s2_d.level = (s1_q.rc == s1_q.rp) && ((s1_q.nc == s1_q.np) || (s1_q.rc == '0));
	end

	pirr_cell #(.W($bits(s2_t))) u_s2 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s1_v), .d (s2_d), .vo (s2_v), .q (s2_q)
	);

	always_comb begin
		s3_d.dx    = s2_q.dx;
		s3_d.dz    = s2_q.dz;
		s3_d.sx    = s2_q.sx;
		s3_d.sz    = s2_q.sz;
		s3_d.quad  = s2_q.quad;
		s3_d.us    = s2_q.us;
		s3_d.uc    = s2_q.uc;
		s3_d.u2s   = s2_q.u2s;
		s3_d.u2c   = s2_q.u2c;
		s3_d.tbs   = POLY_B - trig_mul(POLY_C, s2_q.u2s);
		s3_d.tbc   = POLY_B - trig_mul(POLY_C, s2_q.u2c);
		s3_d.level = s2_q.level;
	end

	pirr_cell #(.W($bits(s3_t))) u_s3 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s2_v), .d (s3_d), .vo (s3_v), .q (s3_q)
	);

	always_comb begin
		s4_d.dx    = s3_q.dx;
		s4_d.dz    = s3_q.dz;
		s4_d.sx    = s3_q.sx;
		s4_d.sz    = s3_q.sz;
		s4_d.quad  = s3_q.quad;
		s4_d.us    = s3_q.us;
		s4_d.uc    = s3_q.uc;
		s4_d.tas   = POLY_A - trig_mul(s3_q.tbs, s3_q.u2s);
		s4_d.tac   = POLY_A - trig_mul(s3_q.tbc, s3_q.u2c);
		s4_d.level = s3_q.level;
	end

	pirr_cell #(.W($bits(s4_t))) u_s4 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s3_v), .d (s4_d), .vo (s4_v), .q (s4_q)
	);

	always_comb begin
		s5_d.dx    = s4_q.dx;
		s5_d.dz    = s4_q.dz;
		s5_d.sx    = s4_q.sx;
		s5_d.sz    = s4_q.sz;
		s5_d.quad  = s4_q.quad;
		s5_d.ss    = trig_mul(s4_q.tas, s4_q.us);
		s5_d.sc    = trig_mul(s4_q.tac, s4_q.uc);
		s5_d.level = s4_q.level;
	end

	pirr_cell #(.W($bits(s5_t))) u_s5 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s4_v), .d (s5_d), .vo (s5_v), .q (s5_q)
	);

	always_comb begin
		pos_s      = $signed({1'b0, s5_q.ss});
		pos_c      = $signed({1'b0, s5_q.sc});
		s6_d.dx    = s5_q.dx;
		s6_d.dz    = s5_q.dz;
		s6_d.sx    = s5_q.sx;
		s6_d.sz    = s5_q.sz;
		s6_d.level = s5_q.level;
		case (s5_q.quad)
			QUAD_0: begin
				s6_d.cs = pos_c;
				s6_d.sn = pos_s;
			end
			QUAD_1: begin
				s6_d.cs = -pos_s;
				s6_d.sn = pos_c;
			end
			QUAD_2: begin
				s6_d.cs = -pos_c;
				s6_d.sn = -pos_s;
			end
			default: begin
				s6_d.cs = pos_s;
				s6_d.sn = -pos_c;
			end
		endcase
	end

	pirr_cell #(.W($bits(s6_t))) u_s6 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s5_v), .d (s6_d), .vo (s6_v), .q (s6_q)
	);

	always_comb begin
		s7_d.pa    = PW'(s6_q.dx) * PW'(s6_q.cs);
		s7_d.pb    = PW'(s6_q.dz) * PW'(s6_q.sn);
		s7_d.pc    = PW'(s6_q.dz) * PW'(s6_q.cs);
		s7_d.pd    = PW'(s6_q.dx) * PW'(s6_q.sn);
		s7_d.sx    = s6_q.sx;
		s7_d.sz    = s6_q.sz;
		s7_d.level = s6_q.level;
	end

	pirr_cell #(.W($bits(s7_t))) u_s7 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s6_v), .d (s7_d), .vo (s7_v), .q (s7_q)
	);

	always_comb begin
		s8_d.qa    = trunc_q(s7_q.pa);
		s8_d.qb    = trunc_q(s7_q.pb);
		s8_d.qc    = trunc_q(s7_q.pc);
		s8_d.qd    = trunc_q(s7_q.pd);
		s8_d.sx    = s7_q.sx;
		s8_d.sz    = s7_q.sz;
		s8_d.level = s7_q.level;
	end

	pirr_cell #(.W($bits(s8_t))) u_s8 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s7_v), .d (s8_d), .vo (s8_v), .q (s8_q)
	);

	always_comb begin
		s9_d.lx    = LW'(s8_q.qa) + LW'(s8_q.qb);
		s9_d.lz    = LW'(s8_q.qc) - LW'(s8_q.qd);
		s9_d.sx    = s8_q.sx;
		s9_d.sz    = s8_q.sz;
		s9_d.level = s8_q.level;
	end

	pirr_cell #(.W($bits(s9_t))) u_s9 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s8_v), .d (s9_d), .vo (s9_v), .q (s9_q)
	);

	// A point on an edge is outside, so both bounds are strict.
	always_comb begin
		lx2       = {s9_q.lx, 1'b0};
		lz2       = {s9_q.lz, 1'b0};
		sxe       = $signed((LW+1)'(s9_q.sx));
		sze       = $signed((LW+1)'(s9_q.sz));
		s10_d.hit = s9_q.level && (lx2 < sxe) && (lx2 > -sxe) && (lz2 < sze) && (lz2 > -sze);
	end

	pirr_cell #(.W($bits(s10_t))) u_s10 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vi (s9_v), .d (s10_d), .vo (s10_v), .q (s10_q)
	);

	assign result_valid = s10_v;
	assign hit          = s10_q.hit;

endmodule

// ===== bench/pirr_hit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the rotated rectangle hit test: watches both channels, predicts each hit and compares.
// Depends on pirr_pkg for the trig constants and the quadrant codes.
module pirr_hit_checker #(
	parameter int COORD_WIDTH = pirr_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = pirr_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS  = pirr_pkg::ANGLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          test_valid,
	input  logic                          test_stall,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic        [COORD_WIDTH-2:0] size_x,
	input  logic        [COORD_WIDTH-2:0] size_z,
	input  logic        [ANGLE_BITS-1:0]  turn_angle,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic                          hit,
	output int                            fail_count,
	output int                            pending_results
);
	import pirr_pkg::*;

	logic awaited_hits[$];
	logic predicted;
	int   results_seen;

	initial begin
		fail_count      = 0;
		pending_results = 0;
		results_seen    = 0;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < 100)
			$display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, what);
		fail_count++;
	endtask

	function automatic longint quarter_wave(input longint u);
		longint u2;
		longint t;
		u2 = (u * u) >> TRIG_FRAC;
		t  = (longint'(POLY_C) * u2) >> TRIG_FRAC;
		t  = longint'(POLY_B) - t;
		t  = (t * u2) >> TRIG_FRAC;
		t  = longint'(POLY_A) - t;
		return (t * u) >> TRIG_FRAC;
	endfunction

	// Product with a Q.20 trig value, truncated toward zero.
	function automatic longint scale_by_trig(input longint d, input longint t);
		longint m;
		m = ((d < 0 ? -d : d) * (t < 0 ? -t : t)) >> TRIG_FRAC;
		return ((d < 0) != (t < 0)) ? -m : m;
	endfunction

	function automatic longint rounded_height(input longint v);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + ((longint'(1) << FRAC_BITS) >> 1)) >> FRAC_BITS;
		return v < 0 ? -m : m;
	endfunction

	function automatic logic predict_hit(
		input logic signed [COORD_WIDTH-1:0] cx, cy, cz,
		input logic        [COORD_WIDTH-2:0] sx, sz,
		input logic        [ANGLE_BITS-1:0]  ang,
		input logic signed [COORD_WIDTH-1:0] px, py, pz
	);
		quad_t  quad;
		longint z, s, c, cs, sn, dx, dz, lx, lz;
		logic   in_rect;
		logic   level;
		quad = quad_t'(ang[ANGLE_BITS-1 -: 2]);
		z = (longint'(ang[ANGLE_BITS-3:0]) << TRIG_FRAC) >> (ANGLE_BITS - 2);
		s = quarter_wave(z);
		c = quarter_wave(longint'(TRIG_ONE) - z);
		case (quad)
			QUAD_0: begin
				cs = c;
				sn = s;
			end
			QUAD_1: begin
				cs = -s;
				sn = c;
			end
			QUAD_2: begin
				cs = -c;
				sn = -s;
			end
			default: begin
				cs = s;
				sn = -c;
			end
		endcase
		dx = longint'(px) - longint'(cx);
		dz = longint'(pz) - longint'(cz);
		lx = scale_by_trig(dx, cs) + scale_by_trig(dz, sn);
		lz = scale_by_trig(dz, cs) - scale_by_trig(dx, sn);
		in_rect = (2 * (lx < 0 ? -lx : lx) < longint'(sx))
			&& (2 * (lz < 0 ? -lz : lz) < longint'(sz));
		level = rounded_height(longint'(cy)) == rounded_height(longint'(py));
		return in_rect && level;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_hits.delete();
			pending_results <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (awaited_hits.size() == 0) begin
					report_mismatch("result word with no test word pending");
				end else begin
					predicted = awaited_hits.pop_front();
					if (hit !== predicted)
						report_mismatch($sformatf("hit is %b, predicted %b", hit, predicted));
				end
				results_seen++;
			end
			if (test_valid && !test_stall)
				awaited_hits.push_back(predict_hit(center_x, center_y, center_z, size_x, size_z,
					turn_angle, point_x, point_y, point_z));
			pending_results <= awaited_hits.size();
		end
	end

endmodule

// ===== bench/tb_point_in_rotated_rect_test_core.sv =====
`timescale 1ns / 1ps
// Testbench top for point_in_rotated_rect_test_core: drives directed and random test words
// with random gaps and result stalls, and gives the verdict. Depends on pirr_pkg and pirr_hit_checker.
module tb_point_in_rotated_rect_test_core;
	import pirr_pkg::*;

	localparam int CW     = COORD_WIDTH_DEF;
	localparam int AW     = ANGLE_BITS_DEF;
	localparam int SIZE_W = CW - 1;

	localparam logic [CW-1:0] ONE       = 32'h0001_0000;
	localparam logic [CW-1:0] HALF      = 32'h0000_8000;
	localparam logic [CW-1:0] COORD_MIN = 32'h8000_0000;
	localparam logic [CW-1:0] COORD_MAX = 32'h7FFF_FFFF;
	localparam logic [CW-1:0] SIZE_MAX  = 32'h7FFF_FFFF;
	localparam logic [CW-1:0] EIGHTH_TURN  = 32'h2000;
	localparam logic [CW-1:0] QUARTER_TURN = 32'h4000;
	localparam logic [CW-1:0] HALF_TURN    = 32'h8000;
	localparam logic [CW-1:0] LAST_ANGLE   = 32'hFFFF;

	localparam int RANDOM_WORDS     = 1200;
	localparam int LONG_HOLD_AFTER  = 200;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 30;
	localparam int CYCLE_LIMIT      = 1000000;

	typedef struct {
		logic signed [CW-1:0]     center_x;
		logic signed [CW-1:0]     center_y;
		logic signed [CW-1:0]     center_z;
		logic        [SIZE_W-1:0] size_x;
		logic        [SIZE_W-1:0] size_z;
		logic        [AW-1:0]     turn_angle;
		logic signed [CW-1:0]     point_x;
		logic signed [CW-1:0]     point_y;
		logic signed [CW-1:0]     point_z;
	} rect_query_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     test_valid   = 1'b0;
	logic                     test_stall;
	logic signed [CW-1:0]     center_x     = '0;
	logic signed [CW-1:0]     center_y     = '0;
	logic signed [CW-1:0]     center_z     = '0;
	logic        [SIZE_W-1:0] size_x       = '0;
	logic        [SIZE_W-1:0] size_z       = '0;
	logic        [AW-1:0]     turn_angle   = '0;
	logic signed [CW-1:0]     point_x      = '0;
	logic signed [CW-1:0]     point_y      = '0;
	logic signed [CW-1:0]     point_z      = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic                     hit;

	int fail_count;
	int pending_results;
	int words_sent = 0;
	int run_left   = 0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	point_in_rotated_rect_test_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.test_valid   (test_valid),
		.test_stall   (test_stall),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.size_x       (size_x),
		.size_z       (size_z),
		.turn_angle   (turn_angle),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.hit          (hit)
	);

	pirr_hit_checker hit_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.test_valid      (test_valid),
		.test_stall      (test_stall),
		.center_x        (center_x),
		.center_y        (center_y),
		.center_z        (center_z),
		.size_x          (size_x),
		.size_z          (size_z),
		.turn_angle      (turn_angle),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.hit             (hit),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic rect_query_t make_query(
		input logic [CW-1:0] cx, cy, cz, sx, sz, ang, px, py, pz
	);
		rect_query_t q;
		q.center_x   = cx;
		q.center_y   = cy;
		q.center_z   = cz;
		q.size_x     = sx[SIZE_W-1:0];
		q.size_z     = sz[SIZE_W-1:0];
		q.turn_angle = ang[AW-1:0];
		q.point_x    = px;
		q.point_y    = py;
		q.point_z    = pz;
		return q;
	endfunction

	function automatic logic [CW-1:0] near_offset(input logic [SIZE_W-1:0] size);
		logic [CW-1:0] d;
		d = CW'($urandom_range(0, size));
		return $urandom_range(0, 1) ? -d : d;
	endfunction

	// Most words place the point near the center at a similar height so that both
	// outcomes of the test come up; the rest are fully random.
	function automatic rect_query_t random_query();
		rect_query_t q;
		q = make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		if ($urandom_range(0, 9) < 7) begin
			q.size_x  = SIZE_W'($urandom) >> $urandom_range(0, SIZE_W - 1);
			q.size_z  = SIZE_W'($urandom) >> $urandom_range(0, SIZE_W - 1);
			q.point_x = q.center_x + near_offset(q.size_x);
			q.point_z = q.center_z + near_offset(q.size_z);
			case ($urandom_range(0, 3))
				0: begin
					q.point_y = q.center_y;
				end
				1: begin
					q.center_y[15:0] = 16'h8000;
					q.point_y = {q.center_y[31:16] + 16'($urandom_range(0, 1)), 16'h0000};
				end
				default: begin
					q.point_y = q.center_y + CW'($urandom_range(0, 32'h20000)) - 32'h10000;
				end
			endcase
			if ($urandom_range(0, 7) == 0)
				q.turn_angle = AW'(QUARTER_TURN * $urandom_range(0, 3));
		end
		return q;
	endfunction

	task automatic send_query(input rect_query_t q);
		int gap;
		test_valid <= 1'b1;
		center_x   <= q.center_x;
		center_y   <= q.center_y;
		center_z   <= q.center_z;
		size_x     <= q.size_x;
		size_z     <= q.size_z;
		turn_angle <= q.turn_angle;
		point_x    <= q.point_x;
		point_y    <= q.point_y;
		point_z    <= q.point_z;
		do
			@(posedge clk);
		while (test_stall);
		words_sent++;
		if (run_left > 0) begin
			run_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 29) == 0)
				run_left = $urandom_range(20, 80);
			gap = pick_gap();
		end
		if (gap > 0) begin
			test_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int  stall_len;
		bit  long_hold_done;
		long_hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && words_sent >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				stall_len = LONG_HOLD_CYCLES;
			end else if ($urandom_range(0, 24) == 0) begin
				stall_len = 0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else begin
				stall_len = pick_gap();
			end
			if (stall_len > 0) begin
				result_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(0, 0, 0, 2 * ONE, 2 * ONE, 0, 0, 0, 0));
		send_query(make_query(0, 0, 0, 4 * ONE, ONE, 0, ONE + HALF, 0, 0));
		send_query(make_query(0, 0, 0, 4 * ONE, ONE, QUARTER_TURN, ONE + HALF, 0, 0));
		send_query(make_query(0, 0, 0, 4 * ONE, ONE, HALF_TURN, ONE + HALF, 0, 0));
		send_query(make_query(0, 0, 0, 4 * ONE, ONE, 3 * QUARTER_TURN, ONE + HALF, 0, 0));
		send_query(make_query(0, 0, 0, 4 * ONE, ONE, 3 * QUARTER_TURN, 0, 0, ONE + HALF));
		// A point on an edge is outside; one step in is inside.
		send_query(make_query(0, 0, 0, 2 * ONE, 2 * ONE, 0, ONE, 0, 0));
		send_query(make_query(0, 0, 0, 2 * ONE, 2 * ONE, 0, ONE - 1, 0, 0));
		send_query(make_query(0, 0, 0, 2 * ONE, 2 * ONE, 0, 0, 0, -ONE));
		send_query(make_query(0, 0, 0, 2 * ONE, 2 * ONE, 0, 0, 0, 1 - ONE));
		// Halfway heights round away from zero.
		send_query(make_query(0, HALF, 0, 2 * ONE, 2 * ONE, 0, 0, ONE, 0));
		send_query(make_query(0, -HALF, 0, 2 * ONE, 2 * ONE, 0, 0, -ONE, 0));
		send_query(make_query(0, -HALF, 0, 2 * ONE, 2 * ONE, 0, 0, 0, 0));
		send_query(make_query(0, HALF - 1, 0, 2 * ONE, 2 * ONE, 0, 0, 0, 0));
		send_query(make_query(0, 32'h7FFF_8000, 0, 2 * ONE, 2 * ONE, 0, 0, COORD_MAX, 0));
		send_query(make_query(0, COORD_MIN, 0, 2 * ONE, 2 * ONE, 0, 0, COORD_MIN, 0));
		send_query(make_query(0, COORD_MIN, 0, 2 * ONE, 2 * ONE, 0, 0, COORD_MAX, 0));
		// Extremes of coordinates, sizes and angle.
		send_query(make_query(0, 0, 0, SIZE_MAX, SIZE_MAX, EIGHTH_TURN, 0, 0, 0));
		send_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, LAST_ANGLE,
			COORD_MAX, COORD_MAX, COORD_MAX));
		send_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, EIGHTH_TURN,
			COORD_MIN, COORD_MIN, COORD_MIN));
		send_query(make_query(0, 0, 0, 2 * ONE, 2 * ONE, EIGHTH_TURN, 32'hE666, 0, 0));
		send_query(make_query(0, 0, 0, 2 * ONE, 2 * ONE, EIGHTH_TURN, 32'hCCCC, 0, 32'hCCCC));
		send_query(make_query(ONE, 0, ONE, 2 * ONE, ONE, LAST_ANGLE, ONE + HALF, HALF, ONE));

		repeat (RANDOM_WORDS)
			send_query(random_query());
		test_valid <= 1'b0;

		do
			@(posedge clk);
		while (pending_results != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_results == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pirr_pkg.sv
sv/pirr_cell.sv
sv/pirr_skid.sv
sv/point_in_rotated_rect_test_core.sv
bench/pirr_hit_checker.sv
bench/tb_point_in_rotated_rect_test_core.sv
